[hw/rtl/handle_table_allocator_top_macros.svh]
// ----------------------------------------------------------------------------
// Handle table allocator assertion macros
// Shared assertion forms, clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef HANDLE_TABLE_ALLOCATOR_TOP_MACROS_SVH
`define HANDLE_TABLE_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define HTA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("handle table allocator check failed");

// Next-cycle implication.
`define HTA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("handle table allocator check failed");

`endif

[hw/rtl/hta_pkg.sv]
// ----------------------------------------------------------------------------
// Handle table allocator package
// Widths, command codes, controller states and control/status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package hta_pkg;

   localparam int CMD_BITS        = 2;
   localparam int HANDLE_BITS     = 13;
   localparam int VALUE_BITS      = 32;
   localparam int TABLE_DEPTH_DEF = 4096;

   localparam logic [CMD_BITS-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_GET    = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic eval;
      logic scan;
      logic load;
   } ctl_type;

   typedef struct packed {
      logic clear_done;
      logic need_scan;
      logic scan_done;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

[hw/rtl/hta_ifs.sv]
// ----------------------------------------------------------------------------
// Handle table allocator channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface hta_req_if;
   import hta_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CMD_BITS-1:0]    cmd;
   logic [HANDLE_BITS-1:0] handle;
   logic [VALUE_BITS-1:0]  value;

   modport source (output valid, output cmd, output handle, output value, input ready);
   modport sink   (input valid, input cmd, input handle, input value, output ready);
endinterface

interface hta_rsp_if;
   import hta_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   status;
   logic [HANDLE_BITS-1:0] handle_out;
   logic [VALUE_BITS-1:0]  value_out;

   modport source (output valid, output status, output handle_out, output value_out,
                   input ready);
   modport sink   (input valid, input status, input handle_out, input value_out,
                   output ready);
endinterface

`default_nettype wire

[hw/rtl/hta_ram.sv]
// ----------------------------------------------------------------------------
// Handle table allocator RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hta_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[hw/rtl/hta_ctrl.sv]
// ----------------------------------------------------------------------------
// Handle table allocator controller
// Sequences the clearing pass, request intake, evaluation, scan and response.
// ----------------------------------------------------------------------------
`default_nettype none

module hta_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire hta_pkg::dp_status_type st,
   output hta_pkg::ctl_type           ctl
);
   import hta_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ctl.clear = 1'b1;
            if (st.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            ctl.accept = req_valid;
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            ctl.eval = 1'b1;
            state_in = st.need_scan ? ST_SCAN : ST_RESP;
         end
         ST_SCAN: begin
            ctl.scan = 1'b1;
            if (st.scan_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (st.out_free) begin
               ctl.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/hta_datapath.sv]
// ----------------------------------------------------------------------------
// Handle table allocator datapath
// Slot memory, free hint, scan pointer, clear counter and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module hta_datapath #(
   parameter int TABLE_DEPTH = hta_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire hta_pkg::ctl_type                ctl,
   output hta_pkg::dp_status_type               st,
   input  wire logic [hta_pkg::CMD_BITS-1:0]    req_cmd,
   input  wire logic [hta_pkg::HANDLE_BITS-1:0] req_handle,
   input  wire logic [hta_pkg::VALUE_BITS-1:0]  req_value,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic                                 rsp_status,
   output logic      [hta_pkg::HANDLE_BITS-1:0] rsp_handle_out,
   output logic      [hta_pkg::VALUE_BITS-1:0]  rsp_value_out
);
   import hta_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int HW = $clog2(TABLE_DEPTH + 2);
   localparam int CW = (HW > HANDLE_BITS) ? HW : HANDLE_BITS;
   localparam logic [HW-1:0] DEPTH_H = HW'(TABLE_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_A  = AW'(TABLE_DEPTH - 1);

   logic [CMD_BITS-1:0]    cmd_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [VALUE_BITS-1:0]  value_ff;
   logic [HW-1:0]          hint_ff;
   logic [HW-1:0]          scan_ff;
   logic [AW-1:0]          clr_ff;
   logic                   res_status_ff;
   logic [HANDLE_BITS-1:0] res_handle_ff;
   logic [VALUE_BITS-1:0]  res_value_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_status_ff;
   logic [HANDLE_BITS-1:0] rsp_handle_ff;
   logic [VALUE_BITS-1:0]  rsp_value_ff;

   logic [CW-1:0]         req_handle_c;
   logic [CW-1:0]         handle_c;
   logic [CW-1:0]         hint_c;
   logic [HW-1:0]         hint_inc;
   logic [HW-1:0]         scan_inc;
   logic                  handle_ok;
   logic                  hint_ok;
   logic                  hint_last;
   logic                  scan_last;
   logic                  slot_empty;
   logic                  add_ok;
   logic                  del_ok;
   logic                  get_ok;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [VALUE_BITS-1:0] mem_wdata;
   logic [AW-1:0]         mem_raddr;
   logic [VALUE_BITS-1:0] mem_rdata;

   hta_ram #(
      .WIDTH(VALUE_BITS),
      .DEPTH(TABLE_DEPTH)
   ) u_slot_ram (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   always_comb begin
      req_handle_c = CW'(req_handle);
      handle_c     = CW'(handle_ff);
      hint_c       = CW'(hint_ff);
      hint_inc     = hint_ff + HW'(1);
      scan_inc     = scan_ff + HW'(1);
      handle_ok    = (handle_ff != '0) && (handle_c <= DEPTH_C);
      hint_ok      = (hint_ff <= DEPTH_H);
      hint_last    = (hint_ff == DEPTH_H);
      scan_last    = (scan_ff == DEPTH_H);
      slot_empty   = (mem_rdata == '0);
      add_ok       = (cmd_ff == CMD_ADD) && hint_ok && slot_empty;
      del_ok       = (cmd_ff == CMD_DELETE) && handle_ok && !slot_empty;
      get_ok       = (cmd_ff == CMD_GET) && handle_ok && !slot_empty;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = AW'(hint_ff - HW'(1));
      mem_wdata = value_ff;
      if (ctl.clear) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (ctl.eval && add_ok) begin
         mem_we = 1'b1;
      end else if (ctl.eval && del_ok) begin
         mem_we    = 1'b1;
         mem_waddr = AW'(handle_c - CW'(1));
         mem_wdata = '0;
      end

      // The scan reads the slot after the one it is checking.
      mem_raddr = AW'(scan_ff);
      if (ctl.accept) begin
         if (req_cmd == CMD_ADD) begin
            mem_raddr = AW'(hint_ff - HW'(1));
         end else begin
            mem_raddr = AW'(req_handle_c - CW'(1));
         end
      end else if (ctl.eval) begin
         mem_raddr = AW'(hint_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hint_ff      <= HW'(1);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.clear) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (ctl.eval && add_ok && hint_last) begin
            hint_ff <= hint_inc;
         end else if (ctl.eval && del_ok && (handle_c < hint_c)) begin
            hint_ff <= HW'(handle_c);
         end else if (ctl.scan) begin
            if (slot_empty) begin
               hint_ff <= scan_ff;
            end else if (scan_last) begin
               hint_ff <= scan_inc;
            end
         end
         if (ctl.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff    <= req_cmd;
         handle_ff <= req_handle;
         value_ff  <= req_value;
      end
      if (ctl.eval) begin
         scan_ff       <= hint_inc;
         res_status_ff <= !(add_ok || del_ok || get_ok);
         res_handle_ff <= add_ok ? HANDLE_BITS'(hint_ff) : '0;
         res_value_ff  <= get_ok ? mem_rdata : '0;
      end else if (ctl.scan) begin
         scan_ff <= scan_inc;
      end
      if (ctl.load) begin
         rsp_status_ff <= res_status_ff;
         rsp_handle_ff <= res_handle_ff;
         rsp_value_ff  <= res_value_ff;
      end
   end

   always_comb begin
      st.clear_done = (clr_ff == LAST_A);
      st.need_scan  = add_ok && !hint_last;
      st.scan_done  = slot_empty || scan_last;
      st.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_value_out  = rsp_value_ff;

endmodule

`default_nettype wire

[hw/rtl/handle_table_allocator_top.sv]
// ----------------------------------------------------------------------------
// Handle table allocator
// Value table addressed by one-based handles with a lowest-free hint.
// ----------------------------------------------------------------------------
// After reset the block clears its slot memory, one slot per cycle, and
// accepts no request during that pass. It then takes one request at a time.
// A get, a delete, an unused command, a failed add and an add into the last
// slot each go from acceptance through the evaluation state to the response
// state, which loads the response register and returns to idle, where the
// next request can be accepted. Any other add scans upward for the next free
// slot, reading one slot per cycle through the single read port of the slot
// memory, with a scan step for every slot that it reads: each occupied slot
// that it passes over, and the free slot where it stops unless it runs off
// the end of the table. A response that has not been taken holds the block in
// its response state until the response register frees up. The next request
// can be accepted while the previous response is still waiting.
`default_nettype none

`include "handle_table_allocator_top_macros.svh"

module handle_table_allocator_top #(
   parameter int TABLE_DEPTH = hta_pkg::TABLE_DEPTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   hta_req_if.sink  req_ch,
   hta_rsp_if.source rsp_ch
);
   import hta_pkg::*;

   ctl_type       ctl;
   dp_status_type st;

   hta_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .st       (st),
      .ctl      (ctl)
   );

   hta_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .st            (st),
      .req_cmd       (req_ch.cmd),
      .req_handle    (req_ch.handle),
      .req_value     (req_ch.value),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_status    (rsp_ch.status),
      .rsp_handle_out(rsp_ch.handle_out),
      .rsp_value_out (rsp_ch.value_out)
   );

   // A response carrying a handle comes from a successful add.
   `HTA_ASSERT_IMPL(a_handle_means_add, (rsp_ch.valid && (rsp_ch.handle_out != '0)), (!rsp_ch.status && (rsp_ch.value_out == '0)))
   `HTA_ASSERT_IMPL(a_error_is_empty, (rsp_ch.valid && rsp_ch.status), ((rsp_ch.handle_out == '0) && (rsp_ch.value_out == '0)))
   `HTA_ASSERT_NEXT(a_one_in_flight, (req_ch.valid && req_ch.ready), (!req_ch.ready))
   `HTA_ASSERT_IMPL(a_clear_blocks_intake, ctl.clear, (!req_ch.ready && !ctl.load))

endmodule

`default_nettype wire

[sim/tb_handle_table_allocator_top.sv]
// ----------------------------------------------------------------------------
// Handle table allocator testbench
// Drives add, delete and get requests into the allocator and checks every
// response against a behavioral copy of the handle table. It runs a directed
// pass, random traffic under three idling mixes, and a run of adds that
// forces long scans.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_handle_table_allocator_top;
   import hta_pkg::*;

   localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam int LIVE_LIMIT = 48;

   typedef struct packed {
      logic                   status;
      logic [HANDLE_BITS-1:0] handle_out;
      logic [VALUE_BITS-1:0]  value_out;
   } table_rsp_type;

   logic clock;
   logic reset;

   hta_req_if req_ch ();
   hta_rsp_if rsp_ch ();

   handle_table_allocator_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [VALUE_BITS-1:0] slot_vals [1:TABLE_DEPTH];
   int                    free_hint;
   int                    live_handles [$];
   table_rsp_type         pending_rsps [$];
   int                    error_count;
   int                    req_gap_pct;
   int                    rsp_stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   // Applies one accepted request to the table copy and returns its response.
   function automatic table_rsp_type apply_table_op(logic [CMD_BITS-1:0] cmd,
                                                    logic [HANDLE_BITS-1:0] handle,
                                                    logic [VALUE_BITS-1:0] value);
      table_rsp_type rsp;
      int            h;
      int            nxt;
      rsp = '{status: 1'b1, handle_out: '0, value_out: '0};
      h = int'(handle);
      case (cmd)
         CMD_ADD: begin
            if (free_hint >= 1 && free_hint <= TABLE_DEPTH) begin
               if (slot_vals[free_hint] == '0) begin
                  slot_vals[free_hint] = value;
                  rsp.status = 1'b0;
                  rsp.handle_out = HANDLE_BITS'(free_hint);
                  if (value != '0) live_handles.push_back(free_hint);
                  nxt = free_hint + 1;
                  while (nxt <= TABLE_DEPTH && slot_vals[nxt] != '0) nxt++;
                  free_hint = nxt;
               end
            end
         end
         CMD_DELETE: begin
            if (h >= 1 && h <= TABLE_DEPTH) begin
               if (slot_vals[h] != '0) begin
                  slot_vals[h] = '0;
                  if (h < free_hint) free_hint = h;
                  rsp.status = 1'b0;
                  for (int i = 0; i < live_handles.size(); i++) begin
                     if (live_handles[i] == h) begin
                        live_handles.delete(i);
                        break;
                     end
                  end
               end
            end
         end
         CMD_GET: begin
            if (h >= 1 && h <= TABLE_DEPTH) begin
               if (slot_vals[h] != '0) begin
                  rsp.status = 1'b0;
                  rsp.value_out = slot_vals[h];
               end
            end
         end
         default: ;
      endcase
      return rsp;
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value(bit allow_zero);
      logic [VALUE_BITS-1:0] v;
      case ($urandom_range(19))
         0: v = allow_zero ? '0 : 32'd1;
         1: v = 32'hFFFF_FFFF;
         2: v = 32'h8000_0000;
         3: v = 32'd1;
         default: v = $urandom;
      endcase
      if (v == '0 && !allow_zero) v = 32'd1;
      return v;
   endfunction

   // Entered and left at a falling edge; the valid stays high on return.
   task automatic send_request(logic [CMD_BITS-1:0] cmd, logic [HANDLE_BITS-1:0] handle,
                               logic [VALUE_BITS-1:0] value);
      while ($urandom_range(99) < req_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.cmd    <= cmd;
      req_ch.handle <= handle;
      req_ch.value  <= value;
      do @(posedge clock); while (!req_ch.ready);
      pending_rsps.push_back(apply_table_op(cmd, handle, value));
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending_rsps.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_request(CMD_GET, 13'd0, 32'h0);
      send_request(CMD_GET, 13'd4097, 32'hFFFF_FFFF);
      send_request(CMD_GET, 13'h1FFF, 32'h0);
      send_request(CMD_DELETE, 13'd0, 32'h0);
      send_request(CMD_DELETE, 13'h1FFF, 32'h0);
      send_request(CMD_DELETE, 13'd5, 32'h0);
      send_request(CMD_GET, 13'd1, 32'h0);
      send_request(CMD_ADD, 13'h1FFF, 32'hFFFF_FFFF);
      send_request(CMD_ADD, 13'd0, 32'd1);
      send_request(CMD_ADD, 13'd0, 32'd0);
      send_request(CMD_ADD, 13'd0, 32'h8000_0000);
      send_request(CMD_GET, 13'd1, 32'h0);
      send_request(CMD_GET, 13'd2, 32'h0);
      send_request(CMD_GET, 13'd3, 32'h0);
      send_request(CMD_GET, 13'd4, 32'h0);
      send_request(CMD_DELETE, 13'd3, 32'h0);
      send_request(CMD_DELETE, 13'd2, 32'h0);
      send_request(CMD_ADD, 13'd0, 32'h1234_5678);
      send_request(CMD_ADD, 13'd0, 32'd7);
      send_request(CMD_UNUSED, 13'd1, 32'hFFFF_FFFF);
      send_request(CMD_GET, 13'd4096, 32'h0);
      send_request(CMD_DELETE, 13'd4096, 32'h0);
      send_request(CMD_DELETE, 13'd1, 32'h0);
      send_request(CMD_GET, 13'd1, 32'h0);
      wait_for_drain();
   endtask

   // Mostly well-formed traffic on live handles, with a share of noise.
   task automatic test_random_traffic(int count, int gap_pct, int stall_pct);
      int                    pick;
      logic [CMD_BITS-1:0]   cmd;
      logic [HANDLE_BITS-1:0] handle;
      req_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) begin
         pick = $urandom_range(99);
         handle = HANDLE_BITS'($urandom_range(8191));
         if (pick < 40 && live_handles.size() >= LIVE_LIMIT) pick = 50;
         if (pick < 88 && pick >= 40 && live_handles.size() == 0) pick = 0;
         if (pick < 40) begin
            cmd = CMD_ADD;
         end else if (pick < 65) begin
            cmd = CMD_DELETE;
            handle = HANDLE_BITS'(live_handles[$urandom_range(live_handles.size() - 1)]);
         end else if (pick < 88) begin
            cmd = CMD_GET;
            handle = HANDLE_BITS'(live_handles[$urandom_range(live_handles.size() - 1)]);
         end else begin
            cmd = CMD_BITS'($urandom_range(3));
            case ($urandom_range(3))
               0: handle = 13'd0;
               1: handle = HANDLE_BITS'(TABLE_DEPTH);
               2: handle = HANDLE_BITS'(TABLE_DEPTH + 1);
               default: ;
            endcase
         end
         send_request(cmd, handle, pick_value(1'b1));
         if ($urandom_range(99) == 0) wait_for_drain();
      end
      wait_for_drain();
   endtask

   // Builds a long run of occupied slots, then frees low slots so that the
   // following adds scan across the whole run.
   task automatic test_long_scan();
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      repeat (80) send_request(CMD_ADD, HANDLE_BITS'($urandom_range(8191)), pick_value(1'b0));
      send_request(CMD_DELETE, 13'd1, 32'h0);
      send_request(CMD_ADD, 13'd0, 32'hFFFF_FFFF);
      send_request(CMD_DELETE, 13'd40, 32'h0);
      send_request(CMD_ADD, 13'd0, 32'h8000_0000);
      send_request(CMD_ADD, 13'd0, 32'd5);
      wait_for_drain();
   endtask

   // Response side: ready changes on the falling edge, responses are taken
   // on the rising edge.
   initial begin
      table_rsp_type want;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsps.size() == 0) begin
               $display("%0t: response with none expected: status %0d handle %0d value %h",
                        $time, rsp_ch.status, rsp_ch.handle_out, rsp_ch.value_out);
               error_count++;
            end else begin
               want = pending_rsps.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_ch.status);
                  error_count++;
               end
               if (rsp_ch.handle_out !== want.handle_out) begin
                  $display("%0t: handle_out mismatch: expected %0d, actual %0d",
                           $time, want.handle_out, rsp_ch.handle_out);
                  error_count++;
               end
               if (rsp_ch.value_out !== want.value_out) begin
                  $display("%0t: value_out mismatch: expected %h, actual %h",
                           $time, want.value_out, rsp_ch.value_out);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_ADD;
      req_ch.handle = '0;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
      error_count = 0;
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      free_hint = 1;
      for (int i = 1; i <= TABLE_DEPTH; i++) slot_vals[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random_traffic(430, 9, 86);
      test_random_traffic(430, 86, 9);
      test_random_traffic(430, 0, 0);
      test_long_scan();

      while (pending_rsps.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
